[rtl/core/oate_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered array table engine package
// Shared sizes, opcode and status codes, and the command type that travels
// from the front end through the command queue to the execution unit.
// ----------------------------------------------------------------------------
package oate_pkg;

    localparam int DEPTH      = 64;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OP_W       = 3;
    localparam int POS_W      = 6;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int CMP_W      = POS_W + 1;
    localparam int S_DATA_W   = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((POS_W + VAL_W + COUNT_W + 7) / 8) * 8;

    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE   = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd3;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NONE   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

endpackage

[rtl/core/oate_front.sv]
// ----------------------------------------------------------------------------
// Ordered array table engine front end
// Accepts requests, drops unknown opcodes and holds one decoded command
// until the command queue takes it.
// ----------------------------------------------------------------------------
module oate_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [oate_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [oate_pkg::OP_W-1:0]     s_tuser,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output oate_pkg::cmd_t                cmd
);
    import oate_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    logic s_accept;
    logic op_known;

    assign s_tready = !hold_valid_reg || cmd_ready;
    assign s_accept = s_tvalid && s_tready;
    assign op_known = (s_tuser == OP_INSERT) || (s_tuser == OP_DELETE) ||
                      (s_tuser == OP_UPDATE) || (s_tuser == OP_SEARCH) ||
                      (s_tuser == OP_TRAVERSE);

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (s_accept) begin
            hold_valid_next = op_known;
        end else if (cmd_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hold_cmd_reg.op    <= s_tuser;
            hold_cmd_reg.pos   <= s_tdata[POS_W-1:0];
            hold_cmd_reg.value <= s_tdata[POS_W+VAL_W-1:POS_W];
        end
    end

    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_cmd_reg;

endmodule

[rtl/core/oate_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// Ordered array table engine command queue
// Short register queue that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
module oate_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  oate_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output oate_pkg::cmd_t out_cmd
);
    import oate_pkg::*;

    cmd_t              slot_reg [CMDQ_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (cnt_reg != QCNT_W'(CMDQ_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(CMDQ_DEPTH))
        else $error("command queue count overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("command queue count missed a push");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("command queue count missed a pop");

endmodule

[rtl/core/oate_exec.sv]
// ----------------------------------------------------------------------------
// Ordered array table engine execution unit
// Holds the entry memory and count, runs the shift and scan walks one entry
// per cycle (scans pause on a stall) and drives the registered result channel.
// ----------------------------------------------------------------------------
module oate_exec (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  oate_pkg::cmd_t                cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [oate_pkg::M_DATA_W-1:0] m_tdata,
    output logic [oate_pkg::STAT_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import oate_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INS   = 3'd1;
    localparam logic [2:0] ST_INSW  = 3'd2;
    localparam logic [2:0] ST_DEL   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;
    localparam logic [2:0] ST_RESP  = 3'd6;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        total_reg, total_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]       dst_reg, dst_next;
    logic                    first_reg, first_next;
    logic [ADDR_W-1:0]       cur_reg, cur_next;
    logic                    held_valid_reg, held_valid_next;
    logic [ADDR_W-1:0]       held_pos_reg, held_pos_next;
    logic signed [VAL_W-1:0] held_val_reg, held_val_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic [POS_W-1:0]        res_pos_reg, res_pos_next;
    logic signed [VAL_W-1:0] res_val_reg, res_val_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;
    logic signed [VAL_W-1:0] out_val_reg, out_val_next;
    logic [COUNT_W-1:0]      out_cnt_reg, out_cnt_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    out_load;
    logic [CMP_W-1:0]        pos_wide;
    logic [CMP_W-1:0]        total_wide;
    logic                    last_elem;
    logic                    is_match;
    logic                    need_emit;

    assign out_free   = !out_valid_reg || m_tready;
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign pos_wide   = {1'b0, cmd.pos};
    assign total_wide = CMP_W'(total_reg);
    assign last_elem  = (CNT_W'(cur_reg) == total_reg - 1'b1);
    assign is_match   = (rd_data_reg == cmd_reg.value);

    always_comb begin
        state_next      = state_reg;
        total_next      = total_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        dst_next        = dst_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        held_valid_next = held_valid_reg;
        held_pos_next   = held_pos_reg;
        held_val_next   = held_val_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_val_next    = res_val_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_val_next    = out_val_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        need_emit       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next     = cmd;
                    res_pos_next = cmd.pos;
                    res_val_next = '0;
                    unique case (cmd.op)
                        OP_INSERT: begin
                            if (total_reg == CNT_W'(DEPTH)) begin
                                res_status_next = STAT_FULL;
                                state_next      = ST_RESP;
                            end else if (pos_wide > total_wide) begin
                                res_status_next = STAT_BADPOS;
                                state_next      = ST_RESP;
                            end else begin
                                res_status_next = STAT_OK;
                                res_val_next    = cmd.value;
                                if (pos_wide == total_wide) begin
                                    wr_en      = 1'b1;
                                    wr_addr    = cmd.pos[ADDR_W-1:0];
                                    wr_data    = cmd.value;
                                    total_next = total_reg + 1'b1;
                                    state_next = ST_RESP;
                                end else begin
                                    rd_en      = 1'b1;
                                    rd_addr    = ADDR_W'(total_reg - 1'b1);
                                    idx_next   = total_reg - 1'b1;
                                    dst_next   = ADDR_W'(total_reg);
                                    state_next = ST_INS;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (pos_wide >= total_wide) begin
                                res_status_next = STAT_BADPOS;
                                state_next      = ST_RESP;
                            end else begin
                                res_status_next = STAT_OK;
                                rd_en           = 1'b1;
                                rd_addr         = cmd.pos[ADDR_W-1:0];
                                idx_next        = CNT_W'(cmd.pos) + 1'b1;
                                first_next      = 1'b1;
                                state_next      = ST_DEL;
                            end
                        end
                        OP_UPDATE: begin
                            if (pos_wide >= total_wide) begin
                                res_status_next = STAT_BADPOS;
                            end else begin
                                res_status_next = STAT_OK;
                                res_val_next    = cmd.value;
                                wr_en           = 1'b1;
                                wr_addr         = cmd.pos[ADDR_W-1:0];
                                wr_data         = cmd.value;
                            end
                            state_next = ST_RESP;
                        end
                        OP_SEARCH, OP_TRAVERSE: begin
                            if (total_reg == '0) begin
                                res_status_next = STAT_NONE;
                                res_pos_next    = '0;
                                state_next      = ST_RESP;
                            end else begin
                                rd_en           = 1'b1;
                                rd_addr         = '0;
                                cur_next        = '0;
                                held_valid_next = 1'b0;
                                state_next      = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS: begin
                wr_en   = 1'b1;
                wr_addr = dst_reg;
                wr_data = rd_data_reg;
                if (idx_reg > CNT_W'(cmd_reg.pos)) begin
                    rd_en    = 1'b1;
                    rd_addr  = ADDR_W'(idx_reg - 1'b1);
                    dst_next = ADDR_W'(idx_reg);
                    idx_next = idx_reg - 1'b1;
                end else begin
                    state_next = ST_INSW;
                end
            end
            ST_INSW: begin
                wr_en      = 1'b1;
                wr_addr    = cmd_reg.pos[ADDR_W-1:0];
                wr_data    = cmd_reg.value;
                total_next = total_reg + 1'b1;
                state_next = ST_RESP;
            end
            ST_DEL: begin
                if (first_reg) begin
                    res_val_next = rd_data_reg;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data_reg;
                end
                first_next = 1'b0;
                if (idx_reg < total_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = ADDR_W'(idx_reg);
                    dst_next = ADDR_W'(idx_reg - 1'b1);
                    idx_next = idx_reg + 1'b1;
                end else begin
                    total_next = total_reg - 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_SCAN: begin
                if (cmd_reg.op == OP_TRAVERSE) begin
                    need_emit       = 1'b1;
                    out_status_next = STAT_OK;
                    out_pos_next    = POS_W'(cur_reg);
                    out_val_next    = rd_data_reg;
                    out_last_next   = last_elem;
                end else begin
                    need_emit       = is_match && held_valid_reg;
                    out_status_next = STAT_OK;
                    out_pos_next    = POS_W'(held_pos_reg);
                    out_val_next    = held_val_reg;
                    out_last_next   = 1'b0;
                end
                out_cnt_next = COUNT_W'(total_reg);
                if (!need_emit || out_free) begin
                    out_load = need_emit;
                    if (cmd_reg.op == OP_SEARCH && is_match) begin
                        held_valid_next = 1'b1;
                        held_pos_next   = cur_reg;
                        held_val_next   = rd_data_reg;
                    end
                    if (last_elem) begin
                        state_next = (cmd_reg.op == OP_TRAVERSE) ? ST_IDLE : ST_FLUSH;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_reg + 1'b1;
                        cur_next = cur_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = held_valid_reg ? STAT_OK : STAT_NONE;
                    out_pos_next    = held_valid_reg ? POS_W'(held_pos_reg) : '0;
                    out_val_next    = held_valid_reg ? held_val_reg : '0;
                    out_cnt_next    = COUNT_W'(total_reg);
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_val_next    = res_val_reg;
                    out_cnt_next    = COUNT_W'(total_reg);
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        dst_reg        <= dst_next;
        first_reg      <= first_next;
        cur_reg        <= cur_next;
        held_valid_reg <= held_valid_next;
        held_pos_reg   <= held_pos_next;
        held_val_reg   <= held_val_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_val_reg    <= res_val_next;
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_pos_reg    <= out_pos_next;
            out_val_reg    <= out_val_next;
            out_cnt_reg    <= out_cnt_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_DATA_W'({out_cnt_reg, out_val_reg, out_pos_reg});

    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write collide on one entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) || (state_reg == ST_FLUSH)) |-> !wr_en)
        else $error("memory written during a scan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg != $past(total_reg)) |->
        ((total_reg == $past(total_reg) + 1'b1) ||
         (total_reg == $past(total_reg) - 1'b1)))
        else $error("entry count moved by more than one");

endmodule

[rtl/core/ordered_array_table_engine.sv]
// ----------------------------------------------------------------------------
// Ordered array table engine
// Dense ordered array of signed 32-bit entries with insert, delete, update,
// search and traverse requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata (low bit first)                 tuser    tlast
//  s_        in         position, operand_value               opcode   -
//  m_        out        found_position, entry_value,          status   last
//                       entry_count
//
// The front end and the command queue each register a request. An insert
// moves the entries from its position on up by one (an append writes at
// once), a delete moves the later entries down, a search or traverse reads
// every entry, and an update, a rejected request or a walk of an empty table
// goes straight to its result. The entry memory has one read and one write
// port and moves one entry per cycle. Reset clears the count and all
// handshake state but not the entries. A stalled result channel holds a scan
// in place and keeps a finished shift waiting at its result, while the front
// end and a two-deep command queue keep taking requests until they fill.
module ordered_array_table_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [oate_pkg::S_DATA_W-1:0] s_tdata,   // position, operand_value
    input  logic [oate_pkg::OP_W-1:0]     s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [oate_pkg::M_DATA_W-1:0] m_tdata,   // found_position, entry_value, entry_count
    output logic [oate_pkg::STAT_W-1:0]   m_tuser,   // status
    output logic                          m_tlast
);
    import oate_pkg::*;

    logic fr_valid;
    logic fr_ready;
    cmd_t fr_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    oate_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    oate_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    oate_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[test/tb_ordered_array_table_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered array table engine testbench
// Sends insert, delete, update, search and traverse requests over the input
// stream and predicts every result from a private copy of the table. Each
// result on the output stream is compared field by field with the oldest
// prediction. A directed opening covers the empty table, the value extremes,
// duplicate matches, bad positions and the unused opcodes. Random runs then
// grow the table until it reports full or 200 requests are sent, shrink it,
// and mix all requests, under changing stalls on both streams.
// ----------------------------------------------------------------------------
module tb_ordered_array_table_engine;

    import oate_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic               last;
    } table_result_t;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} request_mix_t;

    class table_scoreboard;
        logic [VAL_W-1:0] entries [DEPTH];
        int unsigned      total;
        table_result_t    awaited_q[$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      requests [8];
        int unsigned      statuses [4];

        function new();
            total = 0;
            mismatches = 0;
            checked = 0;
            foreach (requests[i]) requests[i] = 0;
            foreach (statuses[i]) statuses[i] = 0;
        endfunction

        function void push_result(logic [STAT_W-1:0] status, int unsigned position,
                                  logic [VAL_W-1:0] value, bit last);
            table_result_t r;
            r.status = status;
            r.position = POS_W'(position);
            r.value = value;
            r.count = COUNT_W'(total);
            r.last = last;
            awaited_q.push_back(r);
            statuses[status]++;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [VAL_W-1:0] value);
            int unsigned      i;
            int unsigned      hits;
            logic [VAL_W-1:0] removed;
            table_result_t    tail;
            hits = 0;
            requests[op]++;
            case (op)
                OP_INSERT: begin
                    if (total >= DEPTH) begin
                        push_result(STAT_FULL, pos, '0, 1'b1);
                    end else if (pos > total) begin
                        push_result(STAT_BADPOS, pos, '0, 1'b1);
                    end else begin
                        for (i = total; i > pos; i--) entries[i] = entries[i - 1];
                        entries[pos] = value;
                        total++;
                        push_result(STAT_OK, pos, value, 1'b1);
                    end
                end
                OP_DELETE: begin
                    if (pos >= total) begin
                        push_result(STAT_BADPOS, pos, '0, 1'b1);
                    end else begin
                        removed = entries[pos];
                        for (i = pos; i + 1 < total; i++) entries[i] = entries[i + 1];
                        total--;
                        push_result(STAT_OK, pos, removed, 1'b1);
                    end
                end
                OP_UPDATE: begin
                    if (pos >= total) begin
                        push_result(STAT_BADPOS, pos, '0, 1'b1);
                    end else begin
                        entries[pos] = value;
                        push_result(STAT_OK, pos, value, 1'b1);
                    end
                end
                OP_SEARCH: begin
                    for (i = 0; i < total; i++) begin
                        if (entries[i] == value) begin
                            push_result(STAT_OK, i, entries[i], 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0) begin
                        push_result(STAT_NONE, 0, '0, 1'b1);
                    end else begin
                        tail = awaited_q.pop_back();
                        tail.last = 1'b1;
                        awaited_q.push_back(tail);
                    end
                end
                OP_TRAVERSE: begin
                    if (total == 0) begin
                        push_result(STAT_NONE, 0, '0, 1'b1);
                    end else begin
                        for (i = 0; i < total; i++)
                            push_result(STAT_OK, i, entries[i], i + 1 == total);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            checked++;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d position %0d value %0d count %0d last %0d",
                             got.status, got.position, $signed(got.value), got.count, got.last);
                return;
            end
            want = awaited_q.pop_front();
            if (got.status !== want.status || got.position !== want.position ||
                got.value !== want.value || got.count !== want.count ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected status %0d position %0d value %0d count %0d last %0d",
                             want.status, want.position, $signed(want.value), want.count,
                             want.last);
                    $display("          actual   status %0d position %0d value %0d count %0d last %0d",
                             got.status, got.position, $signed(got.value), got.count, got.last);
                end
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]   m_tuser;
    logic                m_tlast;

    table_scoreboard sb = new();
    int unsigned     src_idle_pct = 12;
    int unsigned     dst_idle_pct = 57;
    int unsigned     random_sent = 0;
    int unsigned     cycles = 0;

    ordered_array_table_engine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_ordered_array_table_engine: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        table_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.position = m_tdata[POS_W-1:0];
            got.value = m_tdata[POS_W+VAL_W-1:POS_W];
            got.count = m_tdata[POS_W+VAL_W+COUNT_W-1:POS_W+VAL_W];
            got.last = m_tlast;
            sb.check_result(got);
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] value);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_DATA_W'({value, pos});
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, pos, value);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.awaited_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 40) return $urandom;
        case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            default: return 32'h5A5A_A5A5;
        endcase
    endfunction

    task automatic send_random(request_mix_t mix);
        int unsigned      roll;
        int unsigned      total;
        int unsigned      ins_pct;
        int unsigned      del_pct;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        if (random_sent == 100) begin
            src_idle_pct = 57;
            dst_idle_pct = 12;
        end
        if (random_sent == 200) begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
        total = sb.total;
        case (mix)
            MIX_GROW: begin
                ins_pct = 75;
                del_pct = 5;
            end
            MIX_SHRINK: begin
                ins_pct = 10;
                del_pct = 60;
            end
            default: begin
                ins_pct = 30;
                del_pct = 25;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_pct) begin
            op = OP_INSERT;
        end else if (roll < ins_pct + del_pct) begin
            op = OP_DELETE;
        end else begin
            roll = $urandom_range(99);
            if (roll < 35) op = OP_UPDATE;
            else if (roll < 75) op = OP_SEARCH;
            else if (roll < 92) op = OP_TRAVERSE;
            else op = OP_TRAVERSE + OP_W'($urandom_range(1, 3));
        end
        if ($urandom_range(99) < 8) pos = POS_W'($urandom_range(DEPTH - 1));
        else if (op == OP_INSERT) pos = POS_W'($urandom_range(total));
        else if (total == 0) pos = '0;
        else pos = POS_W'($urandom_range(total - 1));
        if (op == OP_SEARCH && total > 0 && $urandom_range(99) < 70)
            value = sb.entries[$urandom_range(total - 1)];
        else
            value = pick_value();
        send_request(op, pos, value);
        random_sent++;
    endtask

    task automatic run_segment(request_mix_t mix, int unsigned min_items);
        int unsigned done;
        done = 0;
        while (done < min_items ||
               (mix == MIX_GROW && sb.statuses[STAT_FULL] == 0 && done < 200)) begin
            send_random(mix);
            done++;
        end
        drain_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Requests against the empty table.
        send_request(OP_TRAVERSE, 0, 32'h0000_0000);
        send_request(OP_SEARCH, 0, 32'h0000_0000);
        send_request(OP_DELETE, 0, 32'h0000_0000);
        send_request(OP_UPDATE, 0, 32'h1234_5678);
        send_request(OP_INSERT, 1, 32'h1111_1111);

        // Extreme values, front, back and middle inserts, duplicate matches.
        send_request(OP_INSERT, 0, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 0, 32'h8000_0000);
        send_request(OP_INSERT, 2, 32'h0000_0000);
        send_request(OP_INSERT, 1, 32'h7FFF_FFFF);
        send_request(OP_SEARCH, 0, 32'h7FFF_FFFF);
        send_request(OP_SEARCH, 0, 32'h0001_2345);
        send_request(OP_UPDATE, 3, 32'hFFFF_FFFF);
        send_request(OP_UPDATE, 4, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 63, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 63, 32'h0000_0000);
        send_request(OP_TRAVERSE + OP_W'(1), 0, 32'hFFFF_FFFF);
        send_request(OP_TRAVERSE + OP_W'(2), 63, 32'h8000_0000);
        send_request(OP_TRAVERSE + OP_W'(3), 21, 32'h7FFF_FFFF);
        send_request(OP_TRAVERSE, 0, 32'h0000_0000);
        send_request(OP_DELETE, 0, 32'h0000_0000);
        send_request(OP_DELETE, POS_W'(sb.total - 1), 32'h0000_0000);
        send_request(OP_DELETE, 1, 32'h0000_0000);
        send_request(OP_TRAVERSE, 0, 32'h0000_0000);
        drain_results();

        run_segment(MIX_GROW, 90);
        run_segment(MIX_SHRINK, 80);
        run_segment(MIX_BALANCED, 130);

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d inserts, %0d deletes, %0d updates, %0d searches, %0d traversals, %0d ignored",
                 sb.requests.sum(), sb.requests[OP_INSERT], sb.requests[OP_DELETE],
                 sb.requests[OP_UPDATE], sb.requests[OP_SEARCH], sb.requests[OP_TRAVERSE],
                 sb.requests.sum() - sb.requests[OP_INSERT] - sb.requests[OP_DELETE] -
                 sb.requests[OP_UPDATE] - sb.requests[OP_SEARCH] - sb.requests[OP_TRAVERSE]);
        $display("checked %0d results, including %0d full-table, %0d bad-position and %0d empty or no-match",
                 sb.checked, sb.statuses[STAT_FULL], sb.statuses[STAT_BADPOS],
                 sb.statuses[STAT_NONE]);
        if (sb.mismatches == 0 && sb.awaited_q.size() == 0) begin
            $display("tb_ordered_array_table_engine: clean");
        end else begin
            $display("tb_ordered_array_table_engine: errors");
        end
        $finish;
    end

endmodule
